FILE: design/pdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared widths, error codes and register map for the particle drift map.
// ----------------------------------------------------------------------------
package pdm_pkg;

    // coordinate format: signed, CW bits, FB fraction bits (Q4.28)
    localparam int CW  = 32;
    localparam int FB  = 28;
    // drift length format: unsigned Q8.24
    localparam int LW  = 32;
    localparam int LF  = 24;

    // extra scaling of the numerators (x/y and ct)
    localparam int XSH = FB - LF;
    localparam int CSH = FB - LF - 1;

    // divisor width (1+delta), numerator widths and their upper parts
    localparam int QW  = CW;
    localparam int NXW = LW + CW + XSH;
    localparam int NXH = NXW - CW;
    localparam int NCW = LW + 2 * CW + CSH;
    localparam int NCH = NCW - CW;

    // pipeline depth: six front stages, division setup, CW divide steps, output
    localparam int PIPE_N = 8 + CW;

    // error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_NONPOS = 2'd1;
    localparam logic [1:0] ERR_SAT    = 2'd2;
    localparam logic [1:0] ERR_RSVD   = 2'd3;

    // register map
    localparam int         ADDR_W           = 3;
    localparam logic [ADDR_W-1:0] REG_DRIFT_LENGTH = 3'd0;

    localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};

    // coordinate plus or minus a clipped increment, saturated; returns {sat, value}
    function automatic logic [CW:0] sat_add(
        input logic [CW-1:0] c,
        input logic          neg,
        input logic          ovf,
        input logic [CW-1:0] quo
    );
        logic [CW-1:0] u;
        logic [CW:0]   inc;
        logic [CW+1:0] sum;
        logic [CW:0]   dif;
        logic          sat;
        logic [CW-1:0] val;
        u   = c ^ HALF;
        inc = ovf ? {1'b1, {CW{1'b0}}} : {1'b0, quo};
        sum = {2'b00, u} + {1'b0, inc};
        dif = {1'b0, u} - inc;
        if (!neg)
        begin
            sat = (sum[CW+1:CW] != 2'b00);
            val = sat ? {CW{1'b1}} : sum[CW-1:0];
        end
        else
        begin
            sat = (inc > {1'b0, u});
            val = sat ? {CW{1'b0}} : dif[CW-1:0];
        end
        return {sat, val ^ HALF};
    endfunction

endpackage
`default_nettype wire

FILE: design/particle_drift_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_drift_map_unit
// Field-free drift of one particle through a drift of configured length.
// ----------------------------------------------------------------------------
// One particle word is taken every cycle unless the pipe is frozen while a
// finished word is held against out_stall. L/(1+delta) and L/(1+delta)^2
// come from restoring dividers that resolve one quotient bit per stage, 32
// stages. Increments are truncated toward zero; quotients of 2^32 or more
// saturate the coordinate. Lost particles and particles with 1+delta <= 0
// pass unchanged (the latter flag error 1). drift_length must be written over
// the APB port only while no word is in flight; the block does not enforce it.

module particle_drift_map_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pdm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [pdm_pkg::CW-1:0]     pos_x,
    input  wire logic [pdm_pkg::CW-1:0]     mom_x,
    input  wire logic [pdm_pkg::CW-1:0]     pos_y,
    input  wire logic [pdm_pkg::CW-1:0]     mom_y,
    input  wire logic [pdm_pkg::CW-1:0]     energy_dev,
    input  wire logic [pdm_pkg::CW-1:0]     path_dev,
    input  wire logic                       lost_in,
    input  wire logic                       last_in,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [pdm_pkg::CW-1:0]     new_pos_x,
    output logic      [pdm_pkg::CW-1:0]     out_mom_x,
    output logic      [pdm_pkg::CW-1:0]     new_pos_y,
    output logic      [pdm_pkg::CW-1:0]     out_mom_y,
    output logic      [pdm_pkg::CW-1:0]     out_energy_dev,
    output logic      [pdm_pkg::CW-1:0]     new_path_dev,
    output logic                            lost_out,
    output logic                            last_out,
    output logic      [1:0]                 error_code
);
    import pdm_pkg::*;

    typedef struct packed {
        logic          lost;
        logic          last;
        logic          bad;
        logic          sx;
        logic          sy;
        logic [CW-1:0] px;
        logic [CW-1:0] x;
        logic [CW-1:0] py;
        logic [CW-1:0] y;
        logic [CW-1:0] dl;
        logic [CW-1:0] ct;
    } side_t;

    typedef struct packed {
        side_t         sd;
        logic [CW-1:0] pm;
        logic [CW-1:0] qm;
        logic [QW-1:0] q;
    } s2_t;

    typedef struct packed {
        side_t           sd;
        logic [QW-1:0]   q;
        logic [2*QW-1:0] dq;
        logic [NXW-1:0]  nx;
        logic [NXW-1:0]  ny;
        logic [2*CW-1:0] pm2;
        logic [2*CW-1:0] qm2;
    } s3_t;

    typedef struct packed {
        side_t           sd;
        logic [QW-1:0]   q;
        logic [2*QW-1:0] dq;
        logic [NXW-1:0]  nx;
        logic [NXW-1:0]  ny;
        logic [2*CW-1:0] ss;
    } s4_t;

    typedef struct packed {
        side_t           sd;
        logic [QW-1:0]   q;
        logic [2*QW-1:0] dq;
        logic [NXW-1:0]  nx;
        logic [NXW-1:0]  ny;
        logic [LW+CW-1:0] p0;
        logic [LW+CW-1:0] p1;
    } s5_t;

    typedef struct packed {
        side_t           sd;
        logic [QW-1:0]   q;
        logic [2*QW-1:0] dq;
        logic [NXW-1:0]  nx;
        logic [NXW-1:0]  ny;
        logic [NCW-1:0]  nc;
    } s6_t;

    typedef struct packed {
        side_t           sd;
        logic [QW-1:0]   q;
        logic [2*QW-1:0] dq;
        logic            ox;
        logic            oy;
        logic            oc;
        logic [QW-1:0]   rx;
        logic [QW-1:0]   ry;
        logic [2*QW-1:0] rc;
        logic [CW-1:0]   wx;
        logic [CW-1:0]   wy;
        logic [CW-1:0]   wc;
    } div_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] px;
        logic [CW-1:0] y;
        logic [CW-1:0] py;
        logic [CW-1:0] dl;
        logic [CW-1:0] ct;
        logic          lost;
        logic          last;
        logic [1:0]    err;
    } out_t;

    // one restoring step on all three dividers; the w word shifts numerator
    // bits out at the top and quotient bits in at the bottom
    function automatic div_t div_step(input div_t d);
        div_t            r;
        logic [QW:0]     tx;
        logic [QW:0]     ty;
        logic [2*QW:0]   tc;
        logic [QW:0]     dx;
        logic [QW:0]     dy;
        logic [2*QW:0]   dc;
        logic            gx;
        logic            gy;
        logic            gc;
        r  = d;
        tx = {d.rx, d.wx[CW-1]};
        ty = {d.ry, d.wy[CW-1]};
        tc = {d.rc, d.wc[CW-1]};
        gx = (tx >= {1'b0, d.q});
        gy = (ty >= {1'b0, d.q});
        gc = (tc >= {1'b0, d.dq});
        dx = tx - {1'b0, d.q};
        dy = ty - {1'b0, d.q};
        dc = tc - {1'b0, d.dq};
        r.rx = gx ? dx[QW-1:0] : tx[QW-1:0];
        r.ry = gy ? dy[QW-1:0] : ty[QW-1:0];
        r.rc = gc ? dc[2*QW-1:0] : tc[2*QW-1:0];
        r.wx = {d.wx[CW-2:0], gx};
        r.wy = {d.wy[CW-2:0], gy};
        r.wc = {d.wc[CW-2:0], gc};
        return r;
    endfunction

    logic [LW-1:0]     drift_length_reg;
    logic [PIPE_N-1:0] pv_reg;
    logic [PIPE_N-1:0] pv_next;
    logic              adv;

    side_t s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    s4_t   s4_reg, s4_next;
    s5_t   s5_reg, s5_next;
    s6_t   s6_reg, s6_next;
    div_t  dv_reg  [0:CW];
    div_t  dv_next [0:CW];
    out_t  out_reg, out_next;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drift_length_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr == REG_DRIFT_LENGTH)
            drift_length_reg <= pwdata;
    end

    always_comb
    begin
        prdata = (paddr == REG_DRIFT_LENGTH) ? drift_length_reg : 32'd0;
    end

    // global advance: the pipe freezes only while a finished word is held
    assign adv      = !(pv_reg[PIPE_N-1] && out_stall);
    assign in_stall = !adv;
    assign pv_next  = {pv_reg[PIPE_N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= pv_next;
    end

    // stage 1: capture the word
    always_comb
    begin
        s1_next      = '0;
        s1_next.lost = lost_in;
        s1_next.last = last_in;
        s1_next.px   = mom_x;
        s1_next.x    = pos_x;
        s1_next.py   = mom_y;
        s1_next.y    = pos_y;
        s1_next.dl   = energy_dev;
        s1_next.ct   = path_dev;
    end

    // stage 2: magnitudes, signs and 1+delta
    always_comb
    begin
        logic [CW:0] qs;
        qs           = {s1_reg.dl[CW-1], s1_reg.dl} + {{(CW-FB){1'b0}}, 1'b1, {FB{1'b0}}};
        s2_next.sd   = s1_reg;
        s2_next.sd.sx  = s1_reg.px[CW-1];
        s2_next.sd.sy  = s1_reg.py[CW-1];
        s2_next.sd.bad = qs[CW] || (qs == '0);
        s2_next.pm   = s1_reg.px[CW-1] ? (~s1_reg.px + 1'b1) : s1_reg.px;
        s2_next.qm   = s1_reg.py[CW-1] ? (~s1_reg.py + 1'b1) : s1_reg.py;
        s2_next.q    = qs[QW-1:0];
    end

    // stage 3: products
    always_comb
    begin
        logic [LW+CW-1:0] mx;
        logic [LW+CW-1:0] my;
        mx          = {{CW{1'b0}}, drift_length_reg} * {{LW{1'b0}}, s2_reg.pm};
        my          = {{CW{1'b0}}, drift_length_reg} * {{LW{1'b0}}, s2_reg.qm};
        s3_next.sd  = s2_reg.sd;
        s3_next.q   = s2_reg.q;
        s3_next.dq  = {{QW{1'b0}}, s2_reg.q} * {{QW{1'b0}}, s2_reg.q};
        s3_next.nx  = {mx, {XSH{1'b0}}};
        s3_next.ny  = {my, {XSH{1'b0}}};
        s3_next.pm2 = {{CW{1'b0}}, s2_reg.pm} * {{CW{1'b0}}, s2_reg.pm};
        s3_next.qm2 = {{CW{1'b0}}, s2_reg.qm} * {{CW{1'b0}}, s2_reg.qm};
    end

    // stage 4: px^2 + py^2 (at most 2^(2*CW-1), no carry out)
    always_comb
    begin
        s4_next.sd = s3_reg.sd;
        s4_next.q  = s3_reg.q;
        s4_next.dq = s3_reg.dq;
        s4_next.nx = s3_reg.nx;
        s4_next.ny = s3_reg.ny;
        s4_next.ss = s3_reg.pm2 + s3_reg.qm2;
    end

    // stage 5: L times the sum, as two partial products
    always_comb
    begin
        s5_next.sd = s4_reg.sd;
        s5_next.q  = s4_reg.q;
        s5_next.dq = s4_reg.dq;
        s5_next.nx = s4_reg.nx;
        s5_next.ny = s4_reg.ny;
        s5_next.p0 = {{CW{1'b0}}, drift_length_reg} * {{LW{1'b0}}, s4_reg.ss[CW-1:0]};
        s5_next.p1 = {{CW{1'b0}}, drift_length_reg} * {{LW{1'b0}}, s4_reg.ss[2*CW-1:CW]};
    end

    // stage 6: combine partial products into the ct numerator
    always_comb
    begin
        logic [LW+2*CW-1:0] lp;
        lp         = {{CW{1'b0}}, s5_reg.p0} + {s5_reg.p1, {CW{1'b0}}};
        s6_next.sd = s5_reg.sd;
        s6_next.q  = s5_reg.q;
        s6_next.dq = s5_reg.dq;
        s6_next.nx = s5_reg.nx;
        s6_next.ny = s5_reg.ny;
        s6_next.nc = {lp, {CSH{1'b0}}};
    end

    // stage 7: divider setup; a quotient of 2^CW or more only needs a flag
    always_comb
    begin
        dv_next[0].sd = s6_reg.sd;
        dv_next[0].q  = s6_reg.q;
        dv_next[0].dq = s6_reg.dq;
        dv_next[0].ox = (s6_reg.nx[NXW-1:CW] >= {{(NXH-QW){1'b0}}, s6_reg.q});
        dv_next[0].oy = (s6_reg.ny[NXW-1:CW] >= {{(NXH-QW){1'b0}}, s6_reg.q});
        dv_next[0].oc = (s6_reg.nc[NCW-1:CW] >= {{(NCH-2*QW){1'b0}}, s6_reg.dq});
        dv_next[0].rx = s6_reg.nx[CW+QW-1:CW];
        dv_next[0].ry = s6_reg.ny[CW+QW-1:CW];
        dv_next[0].rc = s6_reg.nc[CW+2*QW-1:CW];
        dv_next[0].wx = s6_reg.nx[CW-1:0];
        dv_next[0].wy = s6_reg.ny[CW-1:0];
        dv_next[0].wc = s6_reg.nc[CW-1:0];
    end

    // front stage registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            s4_reg    <= s4_next;
            s5_reg    <= s5_next;
            s6_reg    <= s6_next;
            dv_reg[0] <= dv_next[0];
        end
    end

    // divide steps, one quotient bit per stage
    for (genvar k = 1; k <= CW; k++)
    begin : g_div
        assign dv_next[k] = div_step(dv_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[k] <= dv_next[k];
        end
    end

    // final stage: saturating adds and error code
    always_comb
    begin
        logic [CW:0] rx;
        logic [CW:0] ry;
        logic [CW:0] rc;
        div_t        d;
        d  = dv_reg[CW];
        rx = sat_add(d.sd.x,  d.sd.sx, d.ox, d.wx);
        ry = sat_add(d.sd.y,  d.sd.sy, d.oy, d.wy);
        rc = sat_add(d.sd.ct, 1'b0,    d.oc, d.wc);
        out_next.px   = d.sd.px;
        out_next.py   = d.sd.py;
        out_next.dl   = d.sd.dl;
        out_next.lost = d.sd.lost;
        out_next.last = d.sd.last;
        priority if (d.sd.lost)
        begin
            out_next.x   = d.sd.x;
            out_next.y   = d.sd.y;
            out_next.ct  = d.sd.ct;
            out_next.err = ERR_OK;
        end
        else if (d.sd.bad)
        begin
            out_next.x   = d.sd.x;
            out_next.y   = d.sd.y;
            out_next.ct  = d.sd.ct;
            out_next.err = ERR_NONPOS;
        end
        else
        begin
            out_next.x   = rx[CW-1:0];
            out_next.y   = ry[CW-1:0];
            out_next.ct  = rc[CW-1:0];
            out_next.err = (rx[CW] || ry[CW] || rc[CW]) ? ERR_SAT : ERR_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid      = pv_reg[PIPE_N-1];
    assign new_pos_x      = out_reg.x;
    assign out_mom_x      = out_reg.px;
    assign new_pos_y      = out_reg.y;
    assign out_mom_y      = out_reg.py;
    assign out_energy_dev = out_reg.dl;
    assign new_path_dev   = out_reg.ct;
    assign lost_out       = out_reg.lost;
    assign last_out       = out_reg.last;
    assign error_code     = out_reg.err;

    // checks
    a_lost_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lost_out |-> error_code == ERR_OK)
        else $error("lost particle flagged with an error");

    a_no_reserved_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_code != ERR_RSVD)
        else $error("reserved error code on output");

    a_freeze_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pv_reg))
        else $error("pipeline valids moved while frozen");

    a_nonpos_passes_momentum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_NONPOS |-> !lost_out && out_energy_dev[CW-1])
        else $error("nonpositive 1+delta flagged on a non-negative delta");

endmodule
`default_nettype wire

FILE: verif/particle_drift_map_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_drift_map_unit_test
// Streams particle words through the drift unit under several drift lengths
// with random idling on both channels. A scoreboard predicts every result
// word from the accepted particle and checks the output field by field.
// ----------------------------------------------------------------------------

module particle_drift_map_unit_test;
    import pdm_pkg::*;

    typedef struct packed {
        logic [CW-1:0] px, mx, py, my, dlt, ct;
        logic          lost, last;
    } particle_t;

    typedef struct packed {
        logic [CW-1:0] px, mx, py, my, dlt, ct;
        logic          lost, last;
        logic [1:0]    err;
    } drift_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: drift predictor plus queue of pending result words
    // ------------------------------------------------------------------------
    class drift_scoreboard;
        drift_result_t pending[$];
        logic [LW-1:0] length;

        function logic [63:0] magn(logic [CW-1:0] v);
            logic [63:0] sv;
            sv = {{(64-CW){v[CW-1]}}, v};
            return v[CW-1] ? -sv : sv;
        endfunction

        // coordinate plus signed increment, clamped to the coordinate range
        function logic [CW-1:0] clamp_add(logic [CW-1:0] c, logic neg,
                                          logic [127:0] inc, inout logic sat);
            logic signed [131:0] s;
            logic signed [131:0] hi;
            logic signed [131:0] lo;
            hi = (132'sd1 <<< (CW-1)) - 1;
            lo = -(132'sd1 <<< (CW-1));
            s = $signed({{(132-CW){c[CW-1]}}, c});
            s = neg ? s - $signed({4'b0, inc}) : s + $signed({4'b0, inc});
            if (s > hi)
            begin
                sat = 1'b1;
                return hi[CW-1:0];
            end
            if (s < lo)
            begin
                sat = 1'b1;
                return lo[CW-1:0];
            end
            return s[CW-1:0];
        endfunction

        function void note_particle(particle_t p);
            drift_result_t r;
            logic [63:0]  one, dm, q, pm, qm;
            logic [127:0] num, inc;
            logic         sat;
            one = 64'd1 << FB;
            r = '{p.px, p.mx, p.py, p.my, p.dlt, p.ct, p.lost, p.last, ERR_OK};
            sat = 1'b0;
            dm = magn(p.dlt);
            if (!p.lost)
            begin
                if (p.dlt[CW-1] && dm >= one)
                    r.err = ERR_NONPOS;
                else
                begin
                    q  = p.dlt[CW-1] ? one - dm : one + dm;
                    pm = magn(p.mx);
                    qm = magn(p.my);
                    // L*pm*2^FB / (q*2^LF)
                    num = (128'(length) * 128'(pm)) << (FB - LF);
                    inc = num / 128'(q);
                    r.px = clamp_add(p.px, p.mx[CW-1], inc, sat);
                    num = (128'(length) * 128'(qm)) << (FB - LF);
                    inc = num / 128'(q);
                    r.py = clamp_add(p.py, p.my[CW-1], inc, sat);
                    // L*(pm^2+qm^2)*2^FB / (q^2*2^(LF+1))
                    num = (128'(length) * (128'(pm) * pm + 128'(qm) * qm))
                          << (FB - LF - 1);
                    inc = num / (128'(q) * 128'(q));
                    r.ct = clamp_add(p.ct, 1'b0, inc, sat);
                    if (sat)
                        r.err = ERR_SAT;
                end
            end
            pending.push_back(r);
        endfunction

        // returns names of mismatching fields, empty when the word matches
        function string check_result(drift_result_t got);
            drift_result_t e;
            string s;
            if (pending.size() == 0)
                return "unexpected result word";
            e = pending.pop_front();
            s = "";
            if (got.px !== e.px) s = {s, $sformatf(" x %h/%h", got.px, e.px)};
            if (got.mx !== e.mx) s = {s, $sformatf(" px %h/%h", got.mx, e.mx)};
            if (got.py !== e.py) s = {s, $sformatf(" y %h/%h", got.py, e.py)};
            if (got.my !== e.my) s = {s, $sformatf(" py %h/%h", got.my, e.my)};
            if (got.dlt !== e.dlt) s = {s, $sformatf(" dl %h/%h", got.dlt, e.dlt)};
            if (got.ct !== e.ct) s = {s, $sformatf(" ct %h/%h", got.ct, e.ct)};
            if (got.lost !== e.lost) s = {s, " lost"};
            if (got.last !== e.last) s = {s, " last"};
            if (got.err !== e.err) s = {s, $sformatf(" err %0d/%0d", got.err, e.err)};
            return s;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [CW-1:0] pos_x, mom_x, pos_y, mom_y, energy_dev, path_dev;
    logic lost_in, last_in;
    logic [CW-1:0] new_pos_x, out_mom_x, new_pos_y, out_mom_y;
    logic [CW-1:0] out_energy_dev, new_path_dev;
    logic lost_out, last_out;
    logic [1:0] error_code;

    drift_scoreboard sb;
    int  fails;
    int  cycles;
    bit  quiet;
    bit  in_taken;
    bit  out_taken;
    drift_result_t out_word;

    particle_drift_map_unit DUT (.*);

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sample handshakes away from the active edge
    always @(negedge clk)
    begin
        in_taken  <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        out_word  <= '{new_pos_x, out_mom_x, new_pos_y, out_mom_y, out_energy_dev,
                       new_path_dev, lost_out, last_out, error_code};
    end

    task automatic report(string msg);
        $display("mismatch at cycle %0d:%s", cycles, msg);
        fails++;
    endtask

    // result check and timeout
    always @(posedge clk)
    begin
        string s;
        cycles <= cycles + 1;
        if (rst_n && out_taken)
        begin
            s = sb.check_result(out_word);
            if (s != "")
                report(s);
        end
        if (cycles > 2000000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        int run;
        if (!rst_n || quiet)
            out_stall <= 1'b0;
        else if (run > 0)
            run--;
        else
        begin
            run = $urandom_range(1, 16);
            out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic write_length(logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_DRIFT_LENGTH;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.length = v;
    endtask

    task automatic send_particle(particle_t p);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pos_x      <= p.px;
        mom_x      <= p.mx;
        pos_y      <= p.py;
        mom_y      <= p.my;
        energy_dev <= p.dlt;
        path_dev   <= p.ct;
        lost_in    <= p.lost;
        last_in    <= p.last;
        do
            @(posedge clk);
        while (!in_taken);
        sb.note_particle(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_N + 10) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return {1'b0, {(CW-1){1'b1}}} - $urandom_range(0, 3);
            3: return HALF + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_delta();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'hF000_0000 + $urandom_range(0, 4) - 2;
            2: return 32'hF000_0000 - $urandom_range(0, 1 << 24);
            default: return CW'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.px   = rand_coord();
        p.mx   = ($urandom_range(0, 1)) ? rand_coord()
                                        : CW'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        p.py   = rand_coord();
        p.my   = ($urandom_range(0, 1)) ? rand_coord()
                                        : CW'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        p.dlt  = rand_delta();
        p.ct   = rand_coord();
        p.lost = ($urandom_range(0, 9) == 0);
        p.last = $urandom_range(0, 1);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] lengths[5];
        logic [CW-1:0] mx, mn;
        sb = new();
        fails = 0;
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; out_stall = 1'b0;
        pos_x = '0; mom_x = '0; pos_y = '0; mom_y = '0;
        energy_dev = '0; path_dev = '0; lost_in = 1'b0; last_in = 1'b0;
        sb.length = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        mx = {1'b0, {(CW-1){1'b1}}};
        mn = HALF;
        lengths = '{32'h0100_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, $urandom};

        for (int ph = 0; ph < 5; ph++)
        begin
            write_length(lengths[ph]);
            if (ph < 2)
            begin
                // extremes, lost, nonpositive 1+delta, saturation
                send_particle('{'0, '0, '0, '0, '0, '0, 1'b0, 1'b0});
                send_particle('{mx, mx, mx, mx, '0, mx, 1'b0, 1'b1});
                send_particle('{mn, mn, mn, mn, '0, mn, 1'b0, 1'b0});
                send_particle('{mx, mn, mn, mx, mx, '0, 1'b0, 1'b1});
                send_particle('{1, 2, 3, 4, 32'hF000_0000, 5, 1'b0, 1'b0});
                send_particle('{1, 2, 3, 4, 32'hF000_0001, 5, 1'b0, 1'b0});
                send_particle('{1, 2, 3, 4, 32'hEFFF_FFFF, 5, 1'b0, 1'b1});
                send_particle('{1, 2, 3, 4, mn, 5, 1'b0, 1'b0});
                send_particle('{mx, mx, mx, mx, mn, mx, 1'b1, 1'b1});
                send_particle('{mx, 32'h1000_0000, mn, 32'hF000_0000, '0, mx - 3,
                                1'b0, 1'b0});
                send_particle('{mn, 32'hF000_0000, mx, 32'h1000_0000,
                                32'hF000_0001, '0, 1'b0, 1'b1});
                send_particle('{'0, 32'h0100_0000, '0, 32'hFF00_0000,
                                32'h0800_0000, '0, 1'b0, 1'b0});
            end
            for (int i = 0; i < 330; i++)
            begin
                if (ph == 4 && i == 230)
                    quiet = 1'b1;
                if (ph == 2 && i == 150)
                begin
                    // sender holds off until the pipe is empty
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
                send_particle(rand_particle());
            end
            drain();
        end

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
